[sv/modem_join_uplink_sequencer_defines.svh]
// Assertion macros used by the sequencer datapath
`ifndef MODEM_JOIN_UPLINK_SEQUENCER_DEFINES_SVH
`define MODEM_JOIN_UPLINK_SEQUENCER_DEFINES_SVH
// clocked check, held off while reset is high
`define MJUS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("mjus check failed");
// clocked check, also sampled during reset
`define MJUS_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) else $error("mjus check failed");
`endif

[sv/mjus_pkg.sv]
// Package: state numbers, codes and shared types of the join/uplink sequencer
`timescale 1ns / 1ps
package mjus_pkg;
   localparam logic [4:0] ST_STARTUP     = 5'd0;
   localparam logic [4:0] ST_PING        = 5'd1;
   localparam logic [4:0] ST_LAST_SET    = 5'd8;
   localparam logic [4:0] ST_JOIN        = 5'd9;
   localparam logic [4:0] ST_JOIN_WAIT   = 5'd10;
   localparam logic [4:0] ST_ADC_START   = 5'd11;
   localparam logic [4:0] ST_ADC_WAIT    = 5'd12;
   localparam logic [4:0] ST_UPLINK      = 5'd13;
   localparam logic [4:0] ST_UPLINK_WAIT = 5'd14;
   localparam logic [4:0] ST_SLEEP       = 5'd15;
   localparam logic [4:0] ST_FAULT       = 5'd16;

   localparam logic [3:0] CMD_NONE     = 4'd0;
   localparam logic [3:0] CMD_JOIN     = 4'd9;
   localparam logic [3:0] CMD_UPLINK   = 4'd10;
   localparam logic [3:0] CMD_LOWPOWER = 4'd11;

   localparam logic [1:0] OP_BOOT = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_LINE = 2'd2;
   localparam logic [1:0] OP_ADC  = 2'd3;

   localparam logic [2:0] REG_MAX_JOIN   = 3'd0;
   localparam logic [2:0] REG_MAX_UPLINK = 3'd1;
   localparam logic [2:0] REG_SETUP_TO   = 3'd2;
   localparam logic [2:0] REG_JOIN_TO    = 3'd3;
   localparam logic [2:0] REG_UPLINK_TO  = 3'd4;
   localparam logic [2:0] REG_ADC_TO     = 3'd5;
   localparam logic [2:0] REG_BACKOFF    = 3'd6;
   localparam logic [2:0] REG_GAIN       = 3'd7;

   typedef struct packed {
      logic [3:0]  max_join;
      logic [3:0]  max_uplink;
      logic [15:0] setup_to;
      logic [15:0] join_to;
      logic [15:0] uplink_to;
      logic [15:0] adc_to;
      logic [15:0] backoff;
      logic [15:0] gain;
   } cfg_type;

   typedef struct packed {
      logic latch;
      logic exec;
      logic scale;
      logic settle;
   } dp_cmd_type;

   typedef struct packed {
      logic exec_scale;
      logic exec_settle;
      logic settle_done;
   } dp_status_type;
endpackage

[sv/mjus_if.sv]
// Channel interfaces: request items in, result items out
`timescale 1ns / 1ps
interface mjus_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic              adc_ok;
   logic              line_success;
   logic              line_failure;
   logic              line_error;
   logic              line_join_required;
   logic signed [15:0] adc_sample;
   modport source (output valid, opcode, adc_ok, line_success, line_failure, line_error,
                   line_join_required, adc_sample, input ready);
   modport sink (input valid, opcode, adc_ok, line_success, line_failure, line_error,
                 line_join_required, adc_sample, output ready);
endinterface

interface mjus_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  command;
   logic        adc_start;
   logic [13:0] pressure_centi;
   logic [12:0] current_centi;
   logic        sleep_request;
   logic [4:0]  node_state;
   modport source (output valid, command, adc_start, pressure_centi, current_centi,
                   sleep_request, node_state, input ready);
   modport sink (input valid, command, adc_start, pressure_centi, current_centi,
                 sleep_request, node_state, output ready);
endinterface

[sv/mjus_csr.sv]
// Configuration register bank behind the APB-style port
`timescale 1ns / 1ps
module mjus_csr (
   input  logic           clock,
   input  logic           reset,
   input  logic           psel,
   input  logic           penable,
   input  logic           pwrite,
   input  logic [4:0]     paddr,
   input  logic [31:0]    pwdata,
   output logic [31:0]    prdata,
   output logic           pready,
   output mjus_pkg::cfg_type cfg
);
   import mjus_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic [2:0] idx;
   logic       wr;

   assign idx    = paddr[4:2];
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_MAX_JOIN:   cfg_in.max_join   = pwdata[3:0];
            REG_MAX_UPLINK: cfg_in.max_uplink = pwdata[3:0];
            REG_SETUP_TO:   cfg_in.setup_to   = pwdata[15:0];
            REG_JOIN_TO:    cfg_in.join_to    = pwdata[15:0];
            REG_UPLINK_TO:  cfg_in.uplink_to  = pwdata[15:0];
            REG_ADC_TO:     cfg_in.adc_to     = pwdata[15:0];
            REG_BACKOFF:    cfg_in.backoff    = pwdata[15:0];
            REG_GAIN:       cfg_in.gain       = pwdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_MAX_JOIN:   prdata = {28'd0, cfg_ff.max_join};
         REG_MAX_UPLINK: prdata = {28'd0, cfg_ff.max_uplink};
         REG_SETUP_TO:   prdata = {16'd0, cfg_ff.setup_to};
         REG_JOIN_TO:    prdata = {16'd0, cfg_ff.join_to};
         REG_UPLINK_TO:  prdata = {16'd0, cfg_ff.uplink_to};
         REG_ADC_TO:     prdata = {16'd0, cfg_ff.adc_to};
         REG_BACKOFF:    prdata = {16'd0, cfg_ff.backoff};
         REG_GAIN:       prdata = {16'd0, cfg_ff.gain};
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_join   <= 4'd3;
         cfg_ff.max_uplink <= 4'd3;
         cfg_ff.setup_to   <= 16'd3000;
         cfg_ff.join_to    <= 16'd30000;
         cfg_ff.uplink_to  <= 16'd20000;
         cfg_ff.adc_to     <= 16'd200;
         cfg_ff.backoff    <= 16'd2500;
         cfg_ff.gain       <= 16'd4965;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

[sv/mjus_ctrl.sv]
// Controller: steps one item through apply, scale and settle phases
`timescale 1ns / 1ps
module mjus_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  mjus_pkg::dp_status_type  status,
   output mjus_pkg::dp_cmd_type     cmd
);
   import mjus_pkg::*;

   typedef enum logic [4:0] {
      C_IDLE   = 5'b00001,
      C_EXEC   = 5'b00010,
      C_SCALE  = 5'b00100,
      C_SETTLE = 5'b01000,
      C_OUT    = 5'b10000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   assign req_ready  = (state_ff == C_IDLE);
   assign rsp_valid  = (state_ff == C_OUT);
   assign cmd.latch  = (state_ff == C_IDLE) & req_valid;
   assign cmd.exec   = (state_ff == C_EXEC);
   assign cmd.scale  = (state_ff == C_SCALE);
   assign cmd.settle = (state_ff == C_SETTLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         C_IDLE:   if (req_valid) state_in = C_EXEC;
         C_EXEC: begin
            if (status.exec_scale)       state_in = C_SCALE;
            else if (status.exec_settle) state_in = C_SETTLE;
            else                         state_in = C_OUT;
         end
         C_SCALE:  state_in = C_SETTLE;
         C_SETTLE: if (status.settle_done) state_in = C_OUT;
         C_OUT:    if (rsp_ready) state_in = C_IDLE;
         default:  state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= C_IDLE;
      else       state_ff <= state_in;
   end
endmodule

[sv/mjus_dp.sv]
// Datapath: sequencer state, timers, counters and payload scaling
`timescale 1ns / 1ps
module mjus_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  mjus_pkg::cfg_type        cfg,
   input  mjus_pkg::dp_cmd_type     cmd,
   output mjus_pkg::dp_status_type  status,
   input  logic [1:0]               opcode,
   input  logic                     adc_ok,
   input  logic                     line_success,
   input  logic                     line_failure,
   input  logic                     line_error,
   input  logic                     line_join_required,
   input  logic signed [15:0]       adc_sample,
   output logic [3:0]               command,
   output logic                     adc_start,
   output logic [13:0]              pressure_centi,
   output logic [12:0]              current_centi,
   output logic                     sleep_request,
   output logic [4:0]               node_state
);
   import mjus_pkg::*;
   `include "modem_join_uplink_sequencer_defines.svh"

   localparam logic signed [32:0] PRESS_OFFSET = 33'sd26214400;

   // latched item
   logic [1:0]         op_ff;
   logic               ok_ff, succ_ff, fail_ff, err_ff, jr_ff;
   logic signed [15:0] sample_ff;

   logic [4:0]  state_ff, state_in;
   logic        entry_ff, entry_in;
   logic        act_ff, act_in;
   logic [4:0]  on_ok_ff, on_ok_in, on_bad_ff, on_bad_in;
   logic [15:0] cel_ff, cel_in, sel_ff, sel_in, ael_ff, ael_in;
   logic [3:0]  jc_ff, jc_in, uc_ff, uc_in;
   logic        rj_ff, rj_in;
   logic [13:0] pw_ff, pw_in;
   logic [12:0] cw_ff, cw_in;
   logic [3:0]  ocmd_ff, ocmd_in;
   logic        oadc_ff, oadc_in;
   logic signed [32:0] prod_ff;
   logic signed [32:0] prod_in;

   logic        jump, res_en, res_ok, entering;
   logic [4:0]  tgt;
   logic [15:0] se, cel_inc, sel_inc, ael_inc, to_sel;
   logic [32:0] csum;
   logic [32:0] pdiff;
   logic [37:0] pnum;
   logic [37:0] psum;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic signed [32:0] adc_sample_mul(input logic signed [15:0] s,
                                                         input logic [15:0] g);
      adc_sample_mul = 33'(s * $signed({1'b0, g}));
   endfunction

   assign cel_inc  = sat_inc(cel_ff);
   assign sel_inc  = sat_inc(sel_ff);
   assign ael_inc  = sat_inc(ael_ff);
   assign entering = ~entry_ff;
   assign se       = entering ? 16'd0 : sel_ff;
   assign to_sel   = (state_ff == ST_JOIN) ? cfg.join_to :
                     (state_ff == ST_UPLINK) ? cfg.uplink_to : cfg.setup_to;
   assign prod_in  = adc_sample_mul(sample_ff, cfg.gain);

   assign csum  = 33'(prod_ff) + 33'd32768;
   assign pdiff = 33'(prod_ff - PRESS_OFFSET);
   assign pnum  = ({5'd0, pdiff} << 4) + ({5'd0, pdiff} << 3) + {5'd0, pdiff};
   assign psum  = pnum + 38'd131072;

   assign status.exec_scale  = (op_ff == OP_ADC) && (state_ff == ST_ADC_WAIT);
   assign status.exec_settle = (state_ff == ST_STARTUP) ? (op_ff == OP_BOOT) :
                               (state_ff == ST_SLEEP) ? 1'b0 :
                               (op_ff == OP_TICK) || (op_ff == OP_LINE) ||
                               (op_ff == OP_ADC && state_ff == ST_ADC_WAIT);
   assign status.settle_done = entry_in;

   always_comb begin
      state_in = state_ff; entry_in = entry_ff; act_in = act_ff;
      on_ok_in = on_ok_ff; on_bad_in = on_bad_ff;
      cel_in = cel_ff; sel_in = sel_ff; ael_in = ael_ff;
      jc_in = jc_ff; uc_in = uc_ff; rj_in = rj_ff;
      pw_in = pw_ff; cw_in = cw_ff;
      ocmd_in = ocmd_ff; oadc_in = oadc_ff;
      jump = 1'b0; tgt = state_ff; res_en = 1'b0; res_ok = 1'b0;
      if (cmd.latch) begin
         ocmd_in = CMD_NONE;
         oadc_in = 1'b0;
      end else if (cmd.exec) begin
         if (state_ff == ST_STARTUP) begin
            if (op_ff == OP_BOOT) begin
               jump = 1'b1;
               tgt  = ok_ff ? ST_PING : ST_FAULT;
            end
         end else if (state_ff != ST_SLEEP) begin
            case (op_ff)
               OP_TICK: begin
                  cel_in = cel_inc; sel_in = sel_inc; ael_in = ael_inc;
                  if (act_ff && cel_inc >= to_sel) res_en = 1'b1;
               end
               OP_LINE: begin
                  if (jr_ff) rj_in = 1'b1;
                  if (act_ff) begin
                     if (fail_ff || err_ff) res_en = 1'b1;
                     else if (succ_ff) begin
                        res_en = 1'b1; res_ok = 1'b1;
                     end
                  end
               end
               OP_ADC: begin
                  if (state_ff == ST_ADC_WAIT) begin
                     jump = 1'b1; tgt = ST_UPLINK;
                  end
               end
               default: jump = 1'b0;
            endcase
            if (res_en) begin
               act_in = 1'b0; on_ok_in = ST_FAULT; on_bad_in = ST_FAULT;
               jump = 1'b1;
               tgt  = res_ok ? on_ok_ff : on_bad_ff;
               if (res_ok && state_ff == ST_JOIN)   jc_in = 4'd0;
               if (res_ok && state_ff == ST_UPLINK) uc_in = 4'd0;
            end
         end
      end else if (cmd.scale) begin
         // current: round Q16, clamp; pressure: (mA-4)/16 in centi units
         if (prod_ff <= 0) cw_in = 13'd0;
         else if (csum[32:16] > 17'd6553) cw_in = 13'd6553;
         else cw_in = csum[28:16];
         if (prod_ff <= PRESS_OFFSET) pw_in = 14'd0;
         else if (psum[37:18] > 20'd10000) pw_in = 14'd10000;
         else pw_in = psum[31:18];
      end else if (cmd.settle) begin
         if (entering) begin
            entry_in = 1'b1;
            sel_in   = 16'd0;
         end
         case (state_ff)
            ST_STARTUP: jump = 1'b0;
            ST_JOIN: begin
               if (entering) begin
                  rj_in = 1'b0;
                  if (jc_ff >= cfg.max_join) begin
                     jump = 1'b1; tgt = ST_SLEEP;
                  end else begin
                     jc_in = jc_ff + 4'd1;
                     act_in = 1'b1; cel_in = 16'd0;
                     on_ok_in = ST_ADC_START; on_bad_in = ST_JOIN_WAIT;
                     ocmd_in = CMD_JOIN;
                  end
               end
            end
            ST_JOIN_WAIT: begin
               if (se >= cfg.backoff) begin
                  jump = 1'b1; tgt = ST_JOIN;
               end
            end
            ST_ADC_START: begin
               if (entering) begin
                  oadc_in = 1'b1; ael_in = 16'd0;
                  jump = 1'b1; tgt = ST_ADC_WAIT;
               end
            end
            ST_ADC_WAIT: begin
               if (ael_ff >= cfg.adc_to) begin
                  jump = 1'b1; tgt = ST_FAULT;
               end
            end
            ST_UPLINK: begin
               if (entering) begin
                  if (uc_ff >= cfg.max_uplink) begin
                     jump = 1'b1; tgt = ST_SLEEP;
                  end else begin
                     uc_in = uc_ff + 4'd1;
                     act_in = 1'b1; cel_in = 16'd0;
                     on_ok_in = ST_SLEEP; on_bad_in = ST_UPLINK_WAIT;
                     ocmd_in = CMD_UPLINK;
                  end
               end
            end
            ST_UPLINK_WAIT: begin
               if (se >= cfg.backoff) begin
                  jump = 1'b1; tgt = rj_ff ? ST_JOIN : ST_UPLINK;
               end
            end
            ST_SLEEP: begin
               if (entering) begin
                  act_in = 1'b0; on_ok_in = ST_FAULT; on_bad_in = ST_FAULT;
                  ocmd_in = CMD_LOWPOWER;
               end
            end
            ST_FAULT: begin
               if (entering) begin
                  jump = 1'b1; tgt = ST_SLEEP;
               end
            end
            default: begin
               if (state_ff inside {[ST_PING:ST_LAST_SET]}) begin
                  if (entering) begin
                     act_in = 1'b1; cel_in = 16'd0;
                     on_ok_in = state_ff + 5'd1; on_bad_in = ST_FAULT;
                     ocmd_in = state_ff[3:0];
                  end
               end else begin
                  jump = 1'b1; tgt = ST_FAULT;
               end
            end
         endcase
      end
      if (jump && tgt != state_ff) begin
         state_in = tgt;
         entry_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff <= opcode; ok_ff <= adc_ok; succ_ff <= line_success;
         fail_ff <= line_failure; err_ff <= line_error; jr_ff <= line_join_required;
         sample_ff <= adc_sample;
      end
      if (cmd.exec) prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_STARTUP; entry_ff <= 1'b0; act_ff <= 1'b0;
         on_ok_ff <= ST_FAULT; on_bad_ff <= ST_FAULT;
         cel_ff <= 16'd0; sel_ff <= 16'd0; ael_ff <= 16'd0;
         jc_ff <= 4'd0; uc_ff <= 4'd0; rj_ff <= 1'b0;
         pw_ff <= 14'd0; cw_ff <= 13'd0;
         ocmd_ff <= CMD_NONE; oadc_ff <= 1'b0;
      end else begin
         state_ff <= state_in; entry_ff <= entry_in; act_ff <= act_in;
         on_ok_ff <= on_ok_in; on_bad_ff <= on_bad_in;
         cel_ff <= cel_in; sel_ff <= sel_in; ael_ff <= ael_in;
         jc_ff <= jc_in; uc_ff <= uc_in; rj_ff <= rj_in;
         pw_ff <= pw_in; cw_ff <= cw_in;
         ocmd_ff <= ocmd_in; oadc_ff <= oadc_in;
      end
   end

   assign command        = ocmd_ff;
   assign adc_start      = oadc_ff;
   assign pressure_centi = pw_ff;
   assign current_centi  = cw_ff;
   assign sleep_request  = (state_ff == ST_SLEEP);
   assign node_state     = state_ff;

   `MJUS_ASSERT(a_sleep_holds, state_ff == ST_SLEEP |=> state_ff == ST_SLEEP)
   `MJUS_ASSERT(a_cmd_state,
      act_ff |-> ((state_ff >= ST_PING && state_ff <= ST_JOIN) || state_ff == ST_UPLINK))
   `MJUS_ASSERT(a_latch_clears, cmd.latch |=> (ocmd_ff == CMD_NONE && !oadc_ff))
endmodule

[sv/modem_join_uplink_sequencer.sv]
// Top level: modem join/uplink sequencer with APB-style configuration port
//
//  channel   dir   handshake          payload
//  req_if    in    valid/ready        opcode, adc_ok, line flags, adc_sample
//  rsp_if    out   valid/ready        command, adc_start, payload words, state
//  csr       in    psel/penable/pready  paddr, pwdata, prdata
//
// One item at a time: accept, apply the event, an optional scaling step for
// a conversion result, then a settle step for each state visited (none to four),
// then the result item waits in its register until it is taken.
// The settle walk follows chained state entries until one needs no jump.
// Reset is synchronous and clears sequencer state and outputs, not the latched item.
// A stalled result holds the block; no item is taken until it is delivered.
`timescale 1ns / 1ps
module modem_join_uplink_sequencer (
   input  logic        clock,
   input  logic        reset,
   mjus_req_if.sink    req_if,
   mjus_rsp_if.source  rsp_if,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import mjus_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // register bank: eight registers at word addresses
   mjus_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .cfg
   );

   // sequencing of the phases of one item
   mjus_ctrl u_ctrl (
      .clock, .reset,
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status, .cmd
   );

   // state, timers and payload; the outputs are registers
   mjus_dp u_dp (
      .clock, .reset, .cfg, .cmd, .status,
      .opcode             (req_if.opcode),
      .adc_ok             (req_if.adc_ok),
      .line_success       (req_if.line_success),
      .line_failure       (req_if.line_failure),
      .line_error         (req_if.line_error),
      .line_join_required (req_if.line_join_required),
      .adc_sample         (req_if.adc_sample),
      .command            (rsp_if.command),
      .adc_start          (rsp_if.adc_start),
      .pressure_centi     (rsp_if.pressure_centi),
      .current_centi      (rsp_if.current_centi),
      .sleep_request      (rsp_if.sleep_request),
      .node_state         (rsp_if.node_state)
   );
endmodule
